// File: hw/rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL.
// No dependencies; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_HOLDS(lbl, clk, rstn, !(expr), msg)
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: hw/rtl/bps_pkg.sv
// Package for the buzzer pattern sequencer: action codes, register indexes,
// defaults and the pattern ROM with its per-pattern base table. No dependencies.
`default_nettype none
package bps_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_START = 2'd1;
  localparam action_t ACT_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ACTIVE_LOW = 1'b0;
  localparam logic CFG_TPU        = 1'b1;

  localparam int PATTERN_COUNT_DEF = 9;
  localparam int ROM_DEPTH_DEF     = 64;
  localparam logic [7:0] TPU_RESET = 8'd10;

  localparam int ROM_LEN = 60;

  // Zero-terminated on/off duration lists, back to back.
  localparam logic [7:0] ROM_DATA [ROM_LEN] = '{
    8'd2,   8'd100, 8'd0,
    8'd10,  8'd50,  8'd0,
    8'd10,  8'd50,  8'd10,  8'd100, 8'd0,
    8'd10,  8'd50,  8'd10,  8'd50,  8'd10,  8'd100, 8'd0,
    8'd100, 8'd200, 8'd0,
    8'd100, 8'd100, 8'd100, 8'd200, 8'd0,
    8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd200, 8'd0,
    8'd10,  8'd50,  8'd10,  8'd50,  8'd10,  8'd20,  8'd10,  8'd20,
    8'd10,  8'd50,  8'd10,  8'd20,  8'd10,  8'd20,  8'd10,  8'd20,
    8'd10,  8'd50,  8'd10,  8'd20,  8'd10,  8'd150, 8'd0,
    8'd5,   8'd10,  8'd0,
    8'd0
  };

  // Start address of each pattern slot; unused slots point at the lone zero.
  localparam logic [5:0] PAT_BASE [16] = '{
    6'd0,  6'd3,  6'd6,  6'd11, 6'd18, 6'd21, 6'd26, 6'd33,
    6'd56, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59, 6'd59
  };

  // Addresses past the table read as end of list.
  function automatic logic [7:0] rom_read(input logic [6:0] addr);
    logic [7:0] data;
    data = 8'd0;
    if (addr < 7'(ROM_LEN)) begin
      data = ROM_DATA[addr[5:0]];
    end
    return data;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer top level: command decode, step/tick state and
// output register. Depends on bps_pkg and assert_macros.svh.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_ready  | in_action, in_pattern_number, in_repeat_mode
//   out      | out_valid / out_ready| out_buzzer_level, out_playing
//   cfg      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One item per cycle unless the output stalls; each beat's result appears in the
// cycle after acceptance. The state update (ROM read, 8x8 multiply, compare)
// completes in the cycle of acceptance, so the next beat sees it directly.
// in_ready stays high while the result register is empty or being drained.
// Synchronous active-low reset clears playback state and loads config defaults.
`default_nettype none
`include "assert_macros.svh"
module buzzer_pattern_sequencer #(
  parameter int PATTERN_COUNT = bps_pkg::PATTERN_COUNT_DEF,
  parameter int ROM_DEPTH     = bps_pkg::ROM_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [3:0] in_pattern_number,
  input  wire logic       in_repeat_mode,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_buzzer_level,
  output logic            out_playing
);

  // Configuration registers
  logic       active_low_r;
  logic [7:0] tpu_r;

  // Playback state
  logic        running_r, running_nxt;
  logic [3:0]  pattern_r, pattern_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        repeat_r, repeat_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        sound_r, sound_nxt;

  // Output register
  logic out_valid_r;
  logic out_level_r;
  logic out_playing_r;

  logic        in_fire;
  logic [4:0]  step_inc;
  logic [6:0]  addr_cur, addr_next;
  logic [7:0]  entry_cur, entry_next;
  logic [15:0] elapsed_inc;
  logic [15:0] limit;
  logic        stop_fire;
  logic        idle_result;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Look up current and following duration
  assign step_inc  = step_r + 5'd1;
  assign addr_cur  = 7'(bps_pkg::PAT_BASE[pattern_r]) + 7'(step_r);
  assign addr_next = 7'(bps_pkg::PAT_BASE[pattern_r]) + 7'(step_inc);
  assign entry_cur  = (9'(addr_cur) < 9'(ROM_DEPTH)) ? bps_pkg::rom_read(addr_cur) : 8'd0;
  assign entry_next = (9'(addr_next) < 9'(ROM_DEPTH)) ? bps_pkg::rom_read(addr_next) : 8'd0;

  // Saturating tick count and step threshold
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign limit       = 16'(tpu_r) * 16'(entry_cur);

  // Next playback state for the accepted beat
  always_comb begin
    running_nxt = running_r;
    pattern_nxt = pattern_r;
    step_nxt    = step_r;
    repeat_nxt  = repeat_r;
    elapsed_nxt = elapsed_r;
    sound_nxt   = sound_r;
    unique case (in_action)
      bps_pkg::ACT_TICK: begin
        if (running_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= limit) begin
            step_nxt = step_inc;
            if (entry_next == 8'd0 && !repeat_r) begin
              running_nxt = 1'b0;
              sound_nxt   = 1'b0;
            end else begin
              if (entry_next == 8'd0) begin
                step_nxt = 5'd0;
              end
              sound_nxt   = (entry_next == 8'd0) ? 1'b1 : !step_inc[0];
              elapsed_nxt = 16'd0;
            end
          end
        end
      end
      bps_pkg::ACT_START: begin
        if (5'(in_pattern_number) < 5'(PATTERN_COUNT)) begin
          pattern_nxt = in_pattern_number;
          step_nxt    = 5'd0;
          repeat_nxt  = in_repeat_mode;
          elapsed_nxt = 16'd0;
          sound_nxt   = 1'b1;
          running_nxt = 1'b1;
        end
      end
      bps_pkg::ACT_STOP: begin
        running_nxt = 1'b0;
        sound_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
      tpu_r        <= bps_pkg::TPU_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bps_pkg::CFG_ACTIVE_LOW) begin
        active_low_r <= cfg_wdata[0];
      end else if (cfg_index == bps_pkg::CFG_TPU) begin
        tpu_r <= cfg_wdata;
      end
    end
  end

  // Advance playback state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pattern_r <= 4'd0;
      step_r    <= 5'd0;
      repeat_r  <= 1'b0;
      elapsed_r <= 16'd0;
      sound_r   <= 1'b0;
    end else if (in_fire) begin
      running_r <= running_nxt;
      pattern_r <= pattern_nxt;
      step_r    <= step_nxt;
      repeat_r  <= repeat_nxt;
      elapsed_r <= elapsed_nxt;
      sound_r   <= sound_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_level_r   <= sound_nxt ^ active_low_r;
      out_playing_r <= running_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_buzzer_level = out_level_r;
  assign out_playing      = out_playing_r;

  // Terms watched by the checks below
  assign stop_fire   = in_fire && (in_action == bps_pkg::ACT_STOP);
  assign idle_result = out_valid_r && !out_playing_r;

  `ASSERT_NEVER(a_idle_sounds, clk, rst_n, !running_r && sound_r, "sound on while stopped")
  `ASSERT_HOLDS(a_stop_silences, clk, rst_n, stop_fire |=> (!running_r && !sound_r), "stop left on")
  `ASSERT_HOLDS(a_silent_level, clk, rst_n, idle_result |-> (out_level_r == active_low_r), "idle lvl")

endmodule
`default_nettype wire

// File: tb/tb_buzzer_pattern_sequencer.sv
// Self-checking testbench for buzzer_pattern_sequencer: directed commands, config
// extremes, random tick/start/stop traffic with idling and a long output stall.
// Depends on bps_pkg (action codes, register indexes) and the RTL of the block.
`timescale 1ns / 1ps
module tb_buzzer_pattern_sequencer;

  localparam bps_pkg::action_t ACT_UNDEF = 2'd3;
  localparam int NUM_PATTERNS = 9;
  localparam int PAT_ROM_DEPTH = 64;
  localparam int PAT_TABLE_LEN = 60;
  localparam int HOLD_CYCLES = 300;

  // On/off durations per pattern, zero-terminated, back to back.
  localparam logic [7:0] PATTERN_TABLE [PAT_TABLE_LEN] = '{
    8'd2, 8'd100, 8'd0,
    8'd10, 8'd50, 8'd0,
    8'd10, 8'd50, 8'd10, 8'd100, 8'd0,
    8'd10, 8'd50, 8'd10, 8'd50, 8'd10, 8'd100, 8'd0,
    8'd100, 8'd200, 8'd0,
    8'd100, 8'd100, 8'd100, 8'd200, 8'd0,
    8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd200, 8'd0,
    8'd10, 8'd50, 8'd10, 8'd50, 8'd10, 8'd20, 8'd10, 8'd20, 8'd10, 8'd50,
    8'd10, 8'd20, 8'd10, 8'd20, 8'd10, 8'd20, 8'd10, 8'd50,
    8'd10, 8'd20, 8'd10, 8'd150, 8'd0,
    8'd5, 8'd10, 8'd0,
    8'd0
  };
  localparam int PATTERN_START [16] = '{
    0, 3, 6, 11, 18, 21, 26, 33, 56, 59, 59, 59, 59, 59, 59, 59
  };

  typedef struct packed {
    logic level;
    logic playing;
  } buzz_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = bps_pkg::ACT_TICK;
  logic [3:0] in_pattern_number = 4'd0;
  logic in_repeat_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_buzzer_level;
  logic out_playing;

  // Predicted state of the sequencer and its registers.
  logic pred_active_low;
  logic [7:0] pred_tpu;
  logic pred_running;
  logic [3:0] pred_pattern;
  logic [4:0] pred_step;
  logic pred_repeat;
  logic [15:0] pred_elapsed;
  logic pred_sound;

  buzz_result_t pending_levels [$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_requests = 0;
  int err_count = 0;
  int beats_checked = 0;
  int starts_seen = 0;
  int loops_seen = 0;
  int ends_seen = 0;

  buzzer_pattern_sequencer dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_pattern_number(in_pattern_number),
    .in_repeat_mode(in_repeat_mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_buzzer_level(out_buzzer_level),
    .out_playing(out_playing)
  );

  always #6 clk = ~clk;

  // Duration at a step; anything past the table or the ROM reads as end of list.
  function automatic logic [7:0] pattern_entry(input logic [3:0] pat, input logic [4:0] step);
    int addr;
    addr = PATTERN_START[pat] + int'(step);
    if (addr >= PAT_ROM_DEPTH || addr >= PAT_TABLE_LEN) return 8'd0;
    return PATTERN_TABLE[addr];
  endfunction

  // Advance the predicted sequencer by one beat and queue its result.
  task automatic predict_level(input bps_pkg::action_t act, input logic [3:0] pnum,
                               input logic rep);
    int unsigned limit;
    buzz_result_t res;
    case (act)
      bps_pkg::ACT_TICK: begin
        if (pred_running) begin
          if (pred_elapsed != 16'hFFFF) pred_elapsed = pred_elapsed + 16'd1;
          limit = int'(pred_tpu) * int'(pattern_entry(pred_pattern, pred_step));
          if (int'(pred_elapsed) >= limit) begin
            pred_step = pred_step + 5'd1;
            if (pattern_entry(pred_pattern, pred_step) == 8'd0) begin
              if (pred_repeat) begin
                pred_step = 5'd0;
                loops_seen++;
              end else begin
                pred_running = 1'b0;
                pred_sound = 1'b0;
                ends_seen++;
              end
            end
            if (pred_running) begin
              pred_sound = ~pred_step[0];
              pred_elapsed = 16'd0;
            end
          end
        end
      end
      bps_pkg::ACT_START: begin
        if (int'(pnum) < NUM_PATTERNS) begin
          pred_pattern = pnum;
          pred_step = 5'd0;
          pred_repeat = rep;
          pred_elapsed = 16'd0;
          pred_sound = 1'b1;
          pred_running = 1'b1;
          starts_seen++;
        end
      end
      bps_pkg::ACT_STOP: begin
        pred_running = 1'b0;
        pred_sound = 1'b0;
      end
      default: begin
      end
    endcase
    res.level = pred_sound ^ pred_active_low;
    res.playing = pred_running;
    pending_levels.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Offer one beat after a random gap, hold it until accepted, then predict.
  task automatic send_beat(input bps_pkg::action_t act, input logic [3:0] pnum,
                           input logic rep);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pattern_number <= pnum;
    in_repeat_mode <= rep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_level(act, pnum, rep);
  endtask

  // Drop valid and wait until every queued result has been drained.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic al, input logic [7:0] tpu);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_index <= bps_pkg::CFG_ACTIVE_LOW;
    cfg_wdata <= {7'($urandom_range(127)), al};
    @(posedge clk);
    cfg_index <= bps_pkg::CFG_TPU;
    cfg_wdata <= tpu;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_active_low = al;
    pred_tpu = tpu;
  endtask

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin : receiver
    int hold_left;
    int hold_seen;
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    buzz_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result beat with no prediction pending");
      end else begin
        want = pending_levels.pop_front();
        beats_checked++;
        if (out_buzzer_level !== want.level)
          report_mismatch($sformatf("buzzer_level got %b want %b", out_buzzer_level, want.level));
        if (out_playing !== want.playing)
          report_mismatch($sformatf("playing got %b want %b", out_playing, want.playing));
      end
    end
  end

  // Reset defaults, idle ticks, ignored starts, undefined action, stop.
  task automatic test_reset_defaults();
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_START, 4'd15, 1'b1);
    send_beat(bps_pkg::ACT_START, 4'd9, 1'b0);
    send_beat(bps_pkg::ACT_START, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd15, 1'b1);
    send_beat(ACT_UNDEF, 4'd3, 1'b1);
    send_beat(bps_pkg::ACT_STOP, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
  endtask

  // Zero ticks per unit: every tick steps; covers end of list and loop-back.
  task automatic test_zero_tpu_polarity();
    write_config(1'b1, 8'd0);
    send_beat(bps_pkg::ACT_START, 4'd8, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_START, 4'd0, 1'b1);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_STOP, 4'd0, 1'b0);
  endtask

  task automatic test_max_tpu();
    write_config(1'b0, 8'd255);
    send_beat(bps_pkg::ACT_START, 4'd7, 1'b1);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_TICK, 4'd0, 1'b0);
    send_beat(bps_pkg::ACT_STOP, 4'd0, 1'b0);
  endtask

  // Mostly start-then-ticks sequences, with stray stops and undefined actions.
  task automatic test_random_traffic(input int beats, input int s_idle, input int r_idle,
                                     input logic al, input logic [7:0] tpu);
    int counted;
    int roll;
    bps_pkg::action_t act;
    logic [3:0] pnum;
    logic rep;
    write_config(al, tpu);
    send_idle = s_idle;
    recv_idle = r_idle;
    counted = 0;
    while (counted < beats) begin
      roll = $urandom_range(999);
      pnum = 4'($urandom_range(15));
      rep = 1'($urandom_range(1));
      if ((!pred_running && $urandom_range(99) < 40) || roll < 25) begin
        act = bps_pkg::ACT_START;
        if ($urandom_range(99) < 85) pnum = 4'($urandom_range(NUM_PATTERNS - 1));
      end else if (roll < 40) begin
        act = bps_pkg::ACT_STOP;
      end else if (roll < 50) begin
        act = ACT_UNDEF;
      end else begin
        act = bps_pkg::ACT_TICK;
      end
      counted++;
      send_beat(act, pnum, rep);
    end
  endtask

  // Hold the output off while beats keep coming, then pause until drained.
  task automatic test_backpressure();
    int i;
    write_config(1'b1, 8'd1);
    send_idle = 0;
    recv_idle = 0;
    hold_requests++;
    send_beat(bps_pkg::ACT_START, 4'd1, 1'b1);
    for (i = 0; i < 40; i++) begin
      send_beat(bps_pkg::ACT_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
    end
    wait_drain();
  endtask

  initial begin
    pred_active_low = 1'b0;
    pred_tpu = bps_pkg::TPU_RESET;
    pred_running = 1'b0;
    pred_pattern = 4'd0;
    pred_step = 5'd0;
    pred_repeat = 1'b0;
    pred_elapsed = 16'd0;
    pred_sound = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_tpu_polarity();
    test_max_tpu();
    test_random_traffic(210, 20, 84, 1'b0, 8'd1);
    test_random_traffic(210, 20, 84, 1'b1, 8'd1);
    test_backpressure();
    test_random_traffic(210, 84, 20, 1'b1, 8'd2);
    test_random_traffic(210, 84, 20, 1'b0, 8'd0);
    test_random_traffic(210, 0, 0, 1'b1, 8'd3);
    test_random_traffic(210, 0, 0, 1'b0, 8'd1);
    wait_drain();
    repeat (5) @(posedge clk);

    $display("tb: checked %0d result beats over %0d pattern starts", beats_checked, starts_seen);
    $display("tb: %0d loop-backs and %0d pattern ends seen, ticks per unit 0 to 255",
             loops_seen, ends_seen);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
